// ===== design/b64d_pkg.sv =====
// shared types, status codes and character decode for the base64url decoder
// no dependencies
package b64d_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ILLEGAL  = 2'd1;
	localparam logic [1:0] ST_CAPACITY = 2'd2;
	localparam logic [1:0] ST_LEFTOVER = 2'd3;

	localparam logic [7:0] CAP_RESET = 8'd64;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;

	localparam logic [7:0] OFS_LOWER = 8'd26;
	localparam logic [7:0] OFS_DIGIT = 8'd52;
	localparam logic [5:0] VAL_MINUS = 6'd62;
	localparam logic [5:0] VAL_UNDER = 6'd63;

	typedef struct packed {
		logic [11:0] acc;
		logic [2:0]  held;
		logic [7:0]  cnt;
		logic [1:0]  err;
	} b64d_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] byte_count;
	} b64d_res_t;

	typedef struct packed {
		logic       legal;
		logic [5:0] value;
	} b64d_sextet_t;

	function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
		b64d_sextet_t s;
		logic [7:0]   t;
		s = '{legal: 1'b1, value: 6'd0};
		t = 8'd0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			t = c - CH_UPPER_A;
			s.value = t[5:0];
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			t = c - CH_LOWER_A + OFS_LOWER;
			s.value = t[5:0];
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			t = c - CH_DIGIT_0 + OFS_DIGIT;
			s.value = t[5:0];
		end else if (c == CH_MINUS) begin
			s.value = VAL_MINUS;
		end else if (c == CH_UNDER) begin
			s.value = VAL_UNDER;
		end else begin
			s.legal = 1'b0;
		end
		return s;
	endfunction

endpackage

// ===== design/b64d_if.sv =====
// handshake channels for characters in and decode results out
// no dependencies
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source(output valid, char_in, last_char, input ready);
	modport sink(input valid, char_in, last_char, output ready);
endinterface

interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] byte_count;

	modport source(output valid, out_byte, byte_valid, done_res, status, byte_count,
		input ready);
	modport sink(input valid, out_byte, byte_valid, done_res, status, byte_count,
		output ready);
endinterface

// ===== design/b64d_step.sv =====
// one character step: decode, accumulate, emit byte, update error and count
// depends on b64d_pkg
module b64d_step
	import b64d_pkg::*;
(
	input  logic [7:0]  char_in,
	input  logic        last_char,
	input  logic [7:0]  capacity,
	input  b64d_state_t cur,
	output b64d_state_t nxt,
	output b64d_res_t   res
);

	b64d_sextet_t sx;
	b64d_state_t  st;
	logic [3:0]   held_sum;
	logic [11:0]  shifted;
	logic [6:0]   mask_w;
	logic [5:0]   mask;
	logic [7:0]   byte_v;
	logic         valid_v;

	assign sx = sextet_of(char_in);

	always_comb begin
		st       = cur;
		byte_v   = 8'd0;
		valid_v  = 1'b0;
		held_sum = 4'd0;
		shifted  = 12'd0;
		if (cur.err == ST_OK) begin
			if (!sx.legal) begin
				st.err = ST_ILLEGAL;
			end else begin
				st.acc   = {cur.acc[5:0], sx.value};
				held_sum = {1'b0, cur.held} + 4'd6;
				if (held_sum >= 4'd8) begin
					held_sum = held_sum - 4'd8;
					if (cur.cnt >= capacity) begin
						st.err = ST_CAPACITY;
					end else begin
						shifted = st.acc >> held_sum;
						byte_v  = shifted[7:0];
						valid_v = 1'b1;
						st.cnt  = cur.cnt + 8'd1;
					end
				end
				st.held = held_sum[2:0];
			end
		end
		mask_w = (7'd1 << st.held) - 7'd1;
		mask   = mask_w[5:0];
		if (last_char && st.err == ST_OK) begin
			if (st.held >= 3'd6 || (st.acc[5:0] & mask) != 6'd0) begin
				st.err = ST_LEFTOVER;
			end
		end
		res.out_byte   = byte_v;
		res.byte_valid = valid_v;
		res.done_res   = last_char;
		res.status     = st.err;
		res.byte_count = st.cnt;
		if (last_char) begin
			nxt = '0;
		end else begin
			nxt = st;
		end
	end

endmodule

// ===== design/base64url_strict_decoder.sv =====
// top level of the strict base64url decoder, no padding
// depends on b64d_pkg, b64d_if (channels) and b64d_step
//
// channel   dir  width  contents
// in_ch     in   9      char_in[7:0], last_char
// out_ch    out  20     out_byte, byte_valid, done_res, status, byte_count
// cfg       in   8      cfg_we, cfg_wdata -> cap_q (capacity)
//
// one character per cycle sustained while out_ch takes each result; a result is
// offered from the result register once its character has passed the input
// register and is held there until accepted; the decode step and the stream
// state update sit between the input register and the result register
// reset clears the stream state and sets cap_q to 64
// a stalled result holds in the result register while the input register
// still takes one more character
module base64url_strict_decoder
	import b64d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	b64d_in_if.sink      in_ch,
	b64d_out_if.source   out_ch,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic [7:0]  cap_q;
	b64d_state_t state_q;
	b64d_state_t state_nxt;
	b64d_res_t   res;
	b64d_res_t   res_q;
	logic        out_valid_q;
	logic        advance;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.char_in;
			last_s1 <= in_ch.last_char;
		end
	end

	b64d_step u_step (
		.char_in   (char_s1),
		.last_char (last_s1),
		.capacity  (cap_q),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_byte   = res_q.out_byte;
	assign out_ch.byte_valid = res_q.byte_valid;
	assign out_ch.done_res   = res_q.done_res;
	assign out_ch.status     = res_q.status;
	assign out_ch.byte_count = res_q.byte_count;

	a_held_even: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held == 3'd0 || state_q.held == 3'd2 ||
		state_q.held == 3'd4 || state_q.held == 3'd6)
		else $error("bits held left the even range");

	a_byte_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.byte_valid |->
		out_ch.status == ST_OK || out_ch.status == ST_LEFTOVER)
		else $error("byte emitted under an error");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q == '0)
		else $error("stream state not cleared after last character");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 && res.byte_valid |=>
		state_q.cnt == $past(state_q.cnt) + 8'd1)
		else $error("byte count did not advance with an emitted byte");

endmodule
